// ----- rtl/fqs_pkg.sv -----
package fqs_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 5;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic rd_en;    // issue a store read
		logic rd_scan;  // read at the scan pointer instead of the oldest entry
		logic latch;    // capture the incoming word
		logic step;     // advance the search by one entry
		logic finish;   // commit state and load the result register
	} fqs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic search_hit;
		logic search_end;
	} fqs_sts_t;

endpackage

// ----- rtl/fqs_ram.sv -----
module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/fqs_ctrl.sv -----
module fqs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fqs_pkg::cmd_t     cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output fqs_pkg::fqs_cmd_t ctl,
	input  fqs_pkg::fqs_sts_t sts
);

	import fqs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctl.rd_en = 1'b1;
				ctl.latch = in_valid;
			end
			S_EXEC: begin
				ctl.finish = out_free;
			end
			S_SEARCH: begin
				if (sts.search_end || sts.search_hit) begin
					ctl.finish = out_free;
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_scan = 1'b1;
					ctl.step    = 1'b1;
				end
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (cmd == CMD_SEARCH) ? S_SEARCH : S_EXEC;
					end
				end
				S_EXEC: begin
					if (ctl.finish) begin
						state_q <= S_IDLE;
					end
				end
				S_SEARCH: begin
					if (ctl.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/fqs_dp.sv -----
module fqs_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fqs_pkg::cmd_t                    cmd,
	input  logic signed [fqs_pkg::DATA_W-1:0] value,
	input  fqs_pkg::fqs_cmd_t                ctl,
	output fqs_pkg::fqs_sts_t                sts,
	output logic signed [fqs_pkg::DATA_W-1:0] data,
	output logic                             data_valid,
	output logic [fqs_pkg::POS_W-1:0]        position,
	output logic                             found,
	output logic                             overflow,
	output logic                             is_empty
);

	import fqs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
		if (i == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	logic [PTR_W-1:0]  head_q, tail_q, scan_q;
	logic [CNT_W-1:0]  count_q, k_q;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] value_q;

	logic              we;
	logic [PTR_W-1:0]  raddr;
	logic [DATA_W-1:0] rdata;

	logic              full, nonempty;
	logic [CNT_W:0]    k_inc;
	logic [PTR_W-1:0]  head_d, tail_d;
	logic [CNT_W-1:0]  count_d;
	logic [DATA_W-1:0] data_d;
	logic              data_valid_d, found_d, overflow_d;
	logic [POS_W-1:0]  position_d;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign k_inc    = {1'b0, k_q} + 1'b1;
	assign raddr    = ctl.rd_scan ? scan_q : head_q;
	assign we       = ctl.finish && (cmd_q == CMD_PUSH) && !full;

	assign sts.search_end = (k_q >= count_q);
	assign sts.search_hit = !sts.search_end && (rdata == value_q);

	fqs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(tail_q),
		.wdata(value_q),
		.re   (ctl.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		data_d       = '0;
		data_valid_d = 1'b0;
		position_d   = '0;
		found_d      = 1'b0;
		overflow_d   = 1'b0;
		unique case (cmd_q)
			CMD_PUSH: begin
				if (full) begin
					overflow_d = 1'b1;
				end else begin
					tail_d  = ring_next(tail_q);
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (nonempty) begin
					data_d       = rdata;
					data_valid_d = 1'b1;
					if (cmd_q == CMD_POP) begin
						head_d  = ring_next(head_q);
						count_d = count_q - 1'b1;
					end
				end
			end
			CMD_SEARCH: begin
				if (sts.search_hit) begin
					found_d    = 1'b1;
					position_d = POS_W'(k_inc);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.finish) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= cmd;
			value_q <= value;
			scan_q  <= ring_next(head_q);
			k_q     <= '0;
		end else if (ctl.step) begin
			scan_q <= ring_next(scan_q);
			k_q    <= k_inc[CNT_W-1:0];
		end
		if (ctl.finish) begin
			data       <= data_d;
			data_valid <= data_valid_d;
			position   <= position_d;
			found      <= found_d;
			overflow   <= overflow_d;
			is_empty   <= (count_d == '0);
		end
	end

endmodule

// ----- rtl/fifo_queue_with_search.sv -----
// Push, pop and peek: the word is latched and the oldest entry read; the result is registered
// once the output register is free, and only then is the next word taken. Search: the entry walk
// reads one entry per cycle from the oldest, to the first match (position p) or all n entries.
// A finished result waits in the output register while the next word is taken.
// Reset clears the pointers, the entry count and the handshake state; store contents stay
// undefined until pushed.
module fifo_queue_with_search #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  fqs_pkg::cmd_t                    cmd,
	input  logic signed [fqs_pkg::DATA_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [fqs_pkg::DATA_W-1:0] data,
	output logic                             data_valid,
	output logic [fqs_pkg::POS_W-1:0]        position,
	output logic                             found,
	output logic                             overflow,
	output logic                             is_empty
);

	import fqs_pkg::*;

	fqs_cmd_t ctl;
	fqs_sts_t sts;

	fqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	fqs_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.ctl       (ctl),
		.sts       (sts),
		.data      (data),
		.data_valid(data_valid),
		.position  (position),
		.found     (found),
		.overflow  (overflow),
		.is_empty  (is_empty)
	);

endmodule
